[design/wapd_pkg.sv]
// Shared types and constants for the wrapped-angle PD steering block.
// Used by wapd_law and wrapped_angle_pd_steering; depends on nothing else.

package wapd_pkg;

   // Register indexes on the configuration port
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GOAL_COUNT        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COUNTS_PER_TURN   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PROP_GAIN         = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DERIV_GAIN        = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEAD_BAND         = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DEAD_BAND_AT_ZERO = 3'd5;

   // Fixed register widths
   localparam int unsigned TURN_BITS  = 16;
   localparam int unsigned GAIN_BITS  = 10;
   localparam int unsigned BAND_BITS  = 16;
   localparam int unsigned SPEED_BITS = 7;

   // Drive magnitude ceiling
   localparam logic [SPEED_BITS-1:0] SPEED_LIMIT = 7'd100;

   // Reset values
   localparam logic [TURN_BITS-1:0] TURN_RESET      = 16'd4096;
   localparam logic [GAIN_BITS-1:0] PROP_RESET      = 10'd1;
   localparam logic [GAIN_BITS-1:0] DERIV_RESET     = 10'd0;
   localparam logic [BAND_BITS-1:0] BAND_RESET      = 16'd1;
   localparam logic [BAND_BITS-1:0] BAND_ZERO_RESET = 16'd1;

   // Control-law settings that do not depend on the count width
   typedef struct packed {
      logic [TURN_BITS-1:0] counts_per_turn;
      logic [GAIN_BITS-1:0] prop_gain;
      logic [GAIN_BITS-1:0] deriv_gain;
      logic [BAND_BITS-1:0] dead_band;
      logic [BAND_BITS-1:0] dead_band_at_zero;
   } law_cfg_type;

endpackage

[design/wrapped_angle_pd_steering.sv]
// Wrapped-angle PD steering controller: input register, control law, result register.
// Depends on wapd_pkg and wapd_law.
// Samples wait in the input register until the result register is free or draining.
// Throughput: one sample per cycle unless the result side stalls; the stored error follows
// each sample into the result register, so consecutive samples need no gap.
// Reset (synchronous, active high) empties both stages and restores goal, settings and stored error.

module wrapped_angle_pd_steering #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   // Sample channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((COUNT_BITS+7)/8)*8-1:0]       req_tdata,  // [COUNT_BITS-1:0] measured_count
   // Result channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,  // [0] direction, [7:1] speed
   // Configuration writes
   input  logic                                  csr_we,
   input  logic [wapd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [((COUNT_BITS > 16) ? COUNT_BITS : 16)-1:0] csr_wdata
);

   logic [COUNT_BITS-1:0]        goal_ff, goal_in;
   wapd_pkg::law_cfg_type        cfg_ff, cfg_in;
   logic                         s1_valid_ff, s1_valid_in;
   logic [COUNT_BITS-1:0]        count_ff;
   logic signed [COUNT_BITS:0]   prev_error_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         direction_ff;
   logic [wapd_pkg::SPEED_BITS-1:0] speed_ff;
   logic signed [COUNT_BITS:0]   law_error;
   logic                         law_direction;
   logic [wapd_pkg::SPEED_BITS-1:0] law_speed;
   logic                         advance;
   logic                         req_xfer;

   // Register writes
   always_comb begin
      goal_in = goal_ff;
      cfg_in  = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            wapd_pkg::REG_GOAL_COUNT:        goal_in = csr_wdata[COUNT_BITS-1:0];
            wapd_pkg::REG_COUNTS_PER_TURN:   cfg_in.counts_per_turn = csr_wdata[15:0];
            wapd_pkg::REG_PROP_GAIN:         cfg_in.prop_gain = csr_wdata[9:0];
            wapd_pkg::REG_DERIV_GAIN:        cfg_in.deriv_gain = csr_wdata[9:0];
            wapd_pkg::REG_DEAD_BAND:         cfg_in.dead_band = csr_wdata[15:0];
            wapd_pkg::REG_DEAD_BAND_AT_ZERO: cfg_in.dead_band_at_zero = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff                  <= '0;
         cfg_ff.counts_per_turn   <= wapd_pkg::TURN_RESET;
         cfg_ff.prop_gain         <= wapd_pkg::PROP_RESET;
         cfg_ff.deriv_gain        <= wapd_pkg::DERIV_RESET;
         cfg_ff.dead_band         <= wapd_pkg::BAND_RESET;
         cfg_ff.dead_band_at_zero <= wapd_pkg::BAND_ZERO_RESET;
      end else begin
         goal_ff <= goal_in;
         cfg_ff  <= cfg_in;
      end
   end

   // Handshake: the input stage moves on when the result register is free or draining
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !s1_valid_ff || advance;
   assign req_xfer     = req_tvalid && req_tready;
   assign s1_valid_in  = req_xfer || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   wapd_law #(
      .COUNT_BITS(COUNT_BITS)
   ) u_law (
      .goal_count     (goal_ff),
      .measured_count (count_ff),
      .previous_error (prev_error_ff),
      .cfg            (cfg_ff),
      .error          (law_error),
      .direction      (law_direction),
      .speed          (law_speed)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_error_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            prev_error_ff <= law_error;
         end
      end
   end

   // Payload: capture the sample, hold the result until its transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         count_ff <= req_tdata[COUNT_BITS-1:0];
      end
      if (advance) begin
         direction_ff <= law_direction;
         speed_ff     <= law_speed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {speed_ff, direction_ff};

`ifndef SYNTH
   // A sample taken into an empty input stage is held there next cycle
   a_capture: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !s1_valid_ff) |=> s1_valid_ff)
      else $error("accepted sample lost from input stage");

   // A stalled result with a waiting sample blocks new samples
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready && s1_valid_ff) |-> !req_tready)
      else $error("input accepted while both stages are full");

   // The stored error changes only when a sample moves to the result register
   a_prev_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(prev_error_ff))
      else $error("error feedback changed without a sample");

   // Drive never exceeds the limit
   a_speed_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (speed_ff <= wapd_pkg::SPEED_LIMIT))
      else $error("speed above limit");
`endif

endmodule

[design/wapd_law.sv]
// Combinational PD control law with shortest-way angle wrap and dead bands.
// Depends on wapd_pkg for the settings struct and the speed limit.

module wapd_law #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic [COUNT_BITS-1:0]        goal_count,
   input  logic [COUNT_BITS-1:0]        measured_count,
   input  logic signed [COUNT_BITS:0]   previous_error,
   input  wapd_pkg::law_cfg_type        cfg,
   output logic signed [COUNT_BITS:0]   error,
   output logic                         direction,
   output logic [wapd_pkg::SPEED_BITS-1:0] speed
);

   localparam int unsigned ERR_BITS  = COUNT_BITS + 1;
   localparam int unsigned WIDE_BITS =
      ((COUNT_BITS > wapd_pkg::TURN_BITS) ? COUNT_BITS : wapd_pkg::TURN_BITS) + 2;
   localparam int unsigned GAIN_S    = wapd_pkg::GAIN_BITS + 1;
   localparam int unsigned CORR_BITS = ERR_BITS + GAIN_S + 2;

   logic signed [ERR_BITS-1:0]  raw_err;
   logic [ERR_BITS-1:0]         raw_abs;
   logic [WIDE_BITS-1:0]        raw_mag_w;
   logic [WIDE_BITS-1:0]        half_w;
   logic signed [WIDE_BITS-1:0] raw_err_w;
   logic signed [WIDE_BITS-1:0] turn_w;
   logic signed [WIDE_BITS-1:0] wrap_w;
   logic signed [ERR_BITS:0]    err_diff;
   logic signed [GAIN_S-1:0]    kp_s;
   logic signed [GAIN_S-1:0]    kd_s;
   logic signed [CORR_BITS-1:0] p_term;
   logic signed [CORR_BITS-1:0] d_term;
   logic signed [CORR_BITS-1:0] corr;
   logic [CORR_BITS-1:0]        corr_mag;
   logic [ERR_BITS-1:0]         err_abs;
   logic [WIDE_BITS-1:0]        err_mag_w;
   logic                        in_band;
   logic                        in_zero_band;

   // Raw error and its magnitude
   assign raw_err = $signed({1'b0, goal_count}) - $signed({1'b0, measured_count});
   assign raw_abs = raw_err[ERR_BITS-1] ? ERR_BITS'(-raw_err) : raw_err;
   assign raw_mag_w = WIDE_BITS'(raw_abs);
   assign half_w    = WIDE_BITS'(cfg.counts_per_turn >> 1);

   // Move the error one turn toward zero when it spans more than half a turn
   assign raw_err_w = WIDE_BITS'(raw_err);
   assign turn_w    = $signed(WIDE_BITS'(cfg.counts_per_turn));
   always_comb begin
      if (raw_mag_w > half_w) begin
         wrap_w = raw_err[ERR_BITS-1] ? raw_err_w + turn_w : raw_err_w - turn_w;
      end else begin
         wrap_w = raw_err_w;
      end
   end
   // The wrap never grows the magnitude, so the error keeps its width
   assign error = wrap_w[ERR_BITS-1:0];

   // Proportional and derivative terms
   assign err_diff = (ERR_BITS+1)'(error) - (ERR_BITS+1)'(previous_error);
   assign kp_s     = $signed({1'b0, cfg.prop_gain});
   assign kd_s     = $signed({1'b0, cfg.deriv_gain});
   assign p_term   = CORR_BITS'(kp_s) * CORR_BITS'(error);
   assign d_term   = CORR_BITS'(kd_s) * CORR_BITS'(err_diff);
   assign corr     = p_term + d_term;
   assign corr_mag = corr[CORR_BITS-1] ? CORR_BITS'(-corr) : corr;

   // Dead bands on the wrapped error
   assign err_abs      = error[ERR_BITS-1] ? ERR_BITS'(-error) : error;
   assign err_mag_w    = WIDE_BITS'(err_abs);
   assign in_band      = err_mag_w < WIDE_BITS'(cfg.dead_band);
   assign in_zero_band = (goal_count == '0) &&
                         (err_mag_w < WIDE_BITS'(cfg.dead_band_at_zero));

   // Saturate the drive and stop inside either band
   assign direction = ~corr[CORR_BITS-1];
   always_comb begin
      if (in_band || in_zero_band) begin
         speed = '0;
      end else if (corr_mag > CORR_BITS'(wapd_pkg::SPEED_LIMIT)) begin
         speed = wapd_pkg::SPEED_LIMIT;
      end else begin
         speed = corr_mag[wapd_pkg::SPEED_BITS-1:0];
      end
   end

endmodule
